/* sv/pas_pkg.sv */
package pas_pkg;

    // Default sample limit per run
    localparam int MAX_SAMPLES_DEF = 64;

    // Default divider lane widths for the default sample limit
    localparam int DIV_DW_DEF = 40;
    localparam int DIV_VW_DEF = 12;

    // One arc request
    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_z;
        logic signed [31:0] span_time;
        logic signed [31:0] bump_height;
        logic        [7:0]  sample_count;
    } t_req;

    // One emitted sample
    typedef struct packed {
        logic        [5:0]  sample_index;
        logic signed [31:0] sample_time;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               valid_res;
        logic               last;
    } t_smp;

    // Divider lane control
    typedef struct packed {
        logic load;
        logic step;
        logic fix;
    } t_div_ctl;

    // Request setup sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_PROD,
        ST_SUM,
        ST_DIV,
        ST_FIX,
        ST_HOLD
    } t_setup_state;

endpackage

/* sv/pas_if.sv */
interface pas_req_if;
    logic          valid;
    logic          ready;
    pas_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface pas_smp_if;
    logic          valid;
    logic          ready;
    pas_pkg::t_smp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* sv/pas_div_lane.sv */
module pas_div_lane #(
    parameter int DW = pas_pkg::DIV_DW_DEF,
    parameter int VW = pas_pkg::DIV_VW_DEF
) (
    input  logic              i_clk,
    input  pas_pkg::t_div_ctl i_ctl,
    input  logic signed [DW:0] i_num,
    input  logic [VW-1:0]     i_den,
    output logic signed [DW:0] o_quo,
    output logic [VW-1:0]     o_rem
);

    logic              r_neg, n_neg;
    logic [DW-1:0]     r_q, n_q;
    logic [VW-1:0]     r_r, n_r;
    logic signed [DW:0] r_quo, n_quo;
    logic [VW-1:0]     r_rem, n_rem;

    logic [DW:0]       w_mag;
    logic [VW:0]       w_trial;
    logic [VW:0]       w_diff;
    logic              w_fit;

    // Shift-subtract on the magnitude, then floor fixup for negative dividends
    always_comb begin
        w_mag   = i_num[DW] ? (DW+1)'(-i_num) : i_num;
        w_trial = {r_r, r_q[DW-1]};
        w_diff  = w_trial - {1'b0, i_den};
        w_fit   = (w_trial >= {1'b0, i_den});

        n_neg = r_neg;
        n_q   = r_q;
        n_r   = r_r;
        n_quo = r_quo;
        n_rem = r_rem;

        if (i_ctl.load) begin
            n_neg = i_num[DW];
            n_q   = w_mag[DW-1:0];
            n_r   = '0;
        end else if (i_ctl.step) begin
            n_q = {r_q[DW-2:0], w_fit};
            n_r = w_fit ? w_diff[VW-1:0] : w_trial[VW-1:0];
        end else if (i_ctl.fix) begin
            if (!r_neg) begin
                n_quo = $signed({1'b0, r_q});
                n_rem = r_r;
            end else if (r_r == '0) begin
                n_quo = -$signed({1'b0, r_q});
                n_rem = '0;
            end else begin
                // -q - 1 with the remainder folded back into range
                n_quo = ~$signed({1'b0, r_q});
                n_rem = i_den - r_r;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg <= n_neg;
        r_q   <= n_q;
        r_r   <= n_r;
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_quo = r_quo;
    assign o_rem = r_rem;

endmodule

/* sv/parabolic_arc_sampler.sv */
// Parabolic arc sampler.
// i_req (valid/ready) takes one arc request: start and end points, duration,
// lift and sample count. o_smp (valid/ready) returns the samples of the run in
// order, index 0 first, with last set on the final one. A request with a
// non-positive duration or a count below two returns one sample with
// valid_res low, last high and all other fields zero.
// From request accept to the first sample a request passes operand setup, the
// shift-subtract steps of the divider lanes (their magnitude is 34 plus log2
// of MAX_SAMPLES bits wide), the fixup, the hand-off and three output pipeline
// stages. A rejected request skips operand setup and the divider.
// Samples leave at one per cycle while the receiver is ready. The next request
// is set up while the current run is emitted.
// Reset clears the sequencer and every pipeline valid bit; no clearing pass.
// When the receiver stalls, the output register holds and backpressure
// reaches the sample generator; a finished setup waits for the generator.
module parabolic_arc_sampler #(
    parameter int MAX_SAMPLES = pas_pkg::MAX_SAMPLES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pas_req_if.sink   i_req,
    pas_smp_if.source o_smp
);

    localparam int MW = $clog2(MAX_SAMPLES);
    localparam int VW = 2 * MW;
    localparam int DW = 34 + MW;
    localparam int QW = DW + 1;
    localparam int CW = $clog2(DW);
    localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    // Quotient and remainder of a running value over the run divisor
    typedef struct packed {
        logic signed [QW-1:0] q;
        logic [VW-1:0]        r;
    } t_acc;

    // Step an accumulator by an increment, wrapping the remainder
    function automatic t_acc f_adv(input t_acc a, input t_acc d, input logic [VW-1:0] den);
        logic [VW:0] sum;
        logic [VW:0] diff;
        logic        wrap;
        t_acc        res;
        sum   = {1'b0, a.r} + {1'b0, d.r};
        diff  = sum - {1'b0, den};
        wrap  = (sum >= {1'b0, den});
        res.r = wrap ? diff[VW-1:0] : sum[VW-1:0];
        res.q = a.q + d.q + QW'(wrap);
        return res;
    endfunction

    // Round quotient plus remainder to nearest, ties away from zero
    function automatic logic [QW-1:0] f_round(input t_acc a, input logic [VW-1:0] den);
        logic [VW-1:0] half;
        logic          up;
        half = den >> 1;
        if (a.q[QW-1]) begin
            up = (a.r > half);
        end else begin
            up = (({1'b0, a.r} + {1'b0, half}) >= {1'b0, den});
        end
        return a.q + QW'(up);
    endfunction

    // Clamp to the signed 32-bit range
    function automatic logic [31:0] f_sat(input logic [QW-1:0] v);
        logic [QW-32:0] hi;
        hi = v[QW-1:31];
        if ((&hi) || !(|hi)) begin
            return v[31:0];
        end
        return v[QW-1] ? SAT_MIN : SAT_MAX;
    endfunction

    // ---------------------------------------------------------------
    // Request setup
    // ---------------------------------------------------------------
    pas_pkg::t_setup_state r_st, n_st;
    pas_pkg::t_req         r_req;
    pas_pkg::t_div_ctl     w_ctl;
    logic                  r_rej;
    logic signed [32:0]    r_dx, r_dy, r_dz;
    logic [MW-1:0]         r_m;
    logic [VW-1:0]         r_m2;
    logic [30:0]           r_lift;
    logic signed [QW-1:0]  r_dym;
    logic [QW-1:0]         r_lm;
    logic [CW-1:0]         r_cnt;

    logic                  w_req_ready;
    logic                  w_req_fire;
    logic                  w_rej_in;
    logic                  w_setup_hold;
    logic                  w_div_done;
    logic                  w_gen_load;
    logic [7:0]            w_n;
    logic [MW-1:0]         w_m;
    logic [VW-1:0]         w_m_v;
    logic [VW-1:0]         w_m2;
    logic [30:0]           w_lift;
    logic signed [32:0]    w_dx, w_dy, w_dz;
    logic signed [QW-1:0]  w_dy_e, w_m_s, w_dym;
    logic [QW-1:0]         w_l4_e, w_mm1_e, w_lm;
    logic signed [QW-1:0]  w_tnum, w_xnum, w_znum, w_ynum, w_enum;
    logic [VW-1:0]         w_den_m;

    logic signed [QW-1:0]  w_quo_t, w_quo_x, w_quo_z, w_quo_y, w_quo_e;
    logic [VW-1:0]         w_rem_t, w_rem_x, w_rem_z, w_rem_y, w_rem_e;

    assign w_req_fire = i_req.valid && w_req_ready;
    assign w_rej_in   = i_req.payload.span_time[31] || (i_req.payload.span_time == '0) ||
                        (i_req.payload.sample_count < 8'd2);
    assign w_div_done = (r_cnt == CW'(DW - 1));

    // Clamp the count, form deltas and the clamped lift
    assign w_n    = (r_req.sample_count > 8'(MAX_SAMPLES)) ? 8'(MAX_SAMPLES) :
                    r_req.sample_count;
    assign w_m    = MW'(w_n - 8'd1);
    assign w_m_v  = VW'(w_m);
    assign w_m2   = w_m_v * w_m_v;
    assign w_lift = r_req.bump_height[31] ? '0 : r_req.bump_height[30:0];
    assign w_dx   = 33'(r_req.end_x) - 33'(r_req.start_x);
    assign w_dy   = 33'(r_req.end_y) - 33'(r_req.start_y);
    assign w_dz   = 33'(r_req.end_z) - 33'(r_req.start_z);

    // Products for the first y increment: dy*m and 4*lift*(m-1)
    assign w_dy_e  = QW'(r_dy);
    assign w_m_s   = $signed(QW'(r_m));
    assign w_dym   = w_dy_e * w_m_s;
    assign w_l4_e  = QW'({r_lift, 2'b00});
    assign w_mm1_e = QW'(r_m - 1'b1);
    assign w_lm    = w_l4_e * w_mm1_e;

    // Dividends for the lanes
    assign w_tnum  = QW'(r_req.span_time);
    assign w_xnum  = QW'(r_dx);
    assign w_znum  = QW'(r_dz);
    assign w_ynum  = r_dym + $signed(r_lm);
    assign w_enum  = -$signed(QW'({r_lift, 3'b000}));
    assign w_den_m = VW'(r_m);

    // Next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            pas_pkg::ST_IDLE: begin
                if (w_req_fire) begin
                    n_st = w_rej_in ? pas_pkg::ST_HOLD : pas_pkg::ST_DIFF;
                end
            end
            pas_pkg::ST_DIFF: n_st = pas_pkg::ST_PROD;
            pas_pkg::ST_PROD: n_st = pas_pkg::ST_SUM;
            pas_pkg::ST_SUM:  n_st = pas_pkg::ST_DIV;
            pas_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_st = pas_pkg::ST_FIX;
                end
            end
            pas_pkg::ST_FIX:  n_st = pas_pkg::ST_HOLD;
            pas_pkg::ST_HOLD: begin
                if (w_gen_load) begin
                    n_st = pas_pkg::ST_IDLE;
                end
            end
            default: n_st = pas_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        w_req_ready  = 1'b0;
        w_setup_hold = 1'b0;
        w_ctl        = '0;
        case (r_st)
            pas_pkg::ST_IDLE: w_req_ready  = 1'b1;
            pas_pkg::ST_SUM:  w_ctl.load   = 1'b1;
            pas_pkg::ST_DIV:  w_ctl.step   = 1'b1;
            pas_pkg::ST_FIX:  w_ctl.fix    = 1'b1;
            pas_pkg::ST_HOLD: w_setup_hold = 1'b1;
            default: begin
                w_req_ready  = 1'b0;
                w_setup_hold = 1'b0;
            end
        endcase
    end

    assign i_req.ready = w_req_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= pas_pkg::ST_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    // Capture the request and the setup operands
    always_ff @(posedge i_clk) begin
        if (w_req_fire) begin
            r_req <= i_req.payload;
            r_rej <= w_rej_in;
        end
        if (r_st == pas_pkg::ST_DIFF) begin
            r_dx   <= w_dx;
            r_dy   <= w_dy;
            r_dz   <= w_dz;
            r_m    <= w_m;
            r_m2   <= w_m2;
            r_lift <= w_lift;
        end
        if (r_st == pas_pkg::ST_PROD) begin
            r_dym <= w_dym;
            r_lm  <= w_lm;
        end
        if (r_st == pas_pkg::ST_SUM) begin
            r_cnt <= '0;
        end else if (r_st == pas_pkg::ST_DIV) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Divider lanes: time, x and z over m; y increment and its step over m*m
    pas_div_lane #(.DW(DW), .VW(VW)) u_div_t (
        .i_clk(i_clk), .i_ctl(w_ctl), .i_num(w_tnum), .i_den(w_den_m),
        .o_quo(w_quo_t), .o_rem(w_rem_t)
    );
    pas_div_lane #(.DW(DW), .VW(VW)) u_div_x (
        .i_clk(i_clk), .i_ctl(w_ctl), .i_num(w_xnum), .i_den(w_den_m),
        .o_quo(w_quo_x), .o_rem(w_rem_x)
    );
    pas_div_lane #(.DW(DW), .VW(VW)) u_div_z (
        .i_clk(i_clk), .i_ctl(w_ctl), .i_num(w_znum), .i_den(w_den_m),
        .o_quo(w_quo_z), .o_rem(w_rem_z)
    );
    pas_div_lane #(.DW(DW), .VW(VW)) u_div_y (
        .i_clk(i_clk), .i_ctl(w_ctl), .i_num(w_ynum), .i_den(r_m2),
        .o_quo(w_quo_y), .o_rem(w_rem_y)
    );
    pas_div_lane #(.DW(DW), .VW(VW)) u_div_e (
        .i_clk(i_clk), .i_ctl(w_ctl), .i_num(w_enum), .i_den(r_m2),
        .o_quo(w_quo_e), .o_rem(w_rem_e)
    );

    // ---------------------------------------------------------------
    // Sample generator
    // ---------------------------------------------------------------
    logic          r_gen_busy;
    logic          r_gen_rej;
    logic [MW-1:0] r_gen_k;
    logic [MW-1:0] r_gen_m;
    logic [VW-1:0] r_gen_m2;
    t_acc          r_acc_x, r_acc_z, r_acc_t, r_acc_y, r_acc_d;
    t_acc          r_inc_x, r_inc_z, r_inc_t, r_inc_e;
    t_acc          n_acc_x, n_acc_z, n_acc_t, n_acc_y, n_acc_d;
    logic [VW-1:0] w_gen_den;
    logic          w_gen_last;
    logic          w_gen_fire;

    // Pipeline handshake
    logic r_a_v, r_b_v, r_c_v;
    logic w_a_ready, w_b_ready, w_c_ready;

    assign w_c_ready  = !r_c_v || o_smp.ready;
    assign w_b_ready  = !r_b_v || w_c_ready;
    assign w_a_ready  = !r_a_v || w_b_ready;

    assign w_gen_den  = VW'(r_gen_m);
    assign w_gen_last = r_gen_rej || (r_gen_k == r_gen_m);
    assign w_gen_fire = r_gen_busy && w_a_ready;
    assign w_gen_load = w_setup_hold && (!r_gen_busy || (w_gen_fire && w_gen_last));

    // Advance the running numerators by one sample
    assign n_acc_x = f_adv(r_acc_x, r_inc_x, w_gen_den);
    assign n_acc_z = f_adv(r_acc_z, r_inc_z, w_gen_den);
    assign n_acc_t = f_adv(r_acc_t, r_inc_t, w_gen_den);
    assign n_acc_y = f_adv(r_acc_y, r_acc_d, r_gen_m2);
    assign n_acc_d = f_adv(r_acc_d, r_inc_e, r_gen_m2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_busy <= 1'b0;
        end else if (w_gen_load) begin
            r_gen_busy <= 1'b1;
        end else if (w_gen_fire && w_gen_last) begin
            r_gen_busy <= 1'b0;
        end
    end

    // Load a run from setup, or step to the next sample
    always_ff @(posedge i_clk) begin
        if (w_gen_load) begin
            r_gen_rej <= r_rej;
            r_gen_k   <= '0;
            r_gen_m   <= r_m;
            r_gen_m2  <= r_m2;
            r_acc_x   <= '{q: QW'(r_req.start_x), r: '0};
            r_acc_z   <= '{q: QW'(r_req.start_z), r: '0};
            r_acc_y   <= '{q: QW'(r_req.start_y), r: '0};
            r_acc_t   <= '0;
            r_acc_d   <= '{q: w_quo_y, r: w_rem_y};
            r_inc_x   <= '{q: w_quo_x, r: w_rem_x};
            r_inc_z   <= '{q: w_quo_z, r: w_rem_z};
            r_inc_t   <= '{q: w_quo_t, r: w_rem_t};
            r_inc_e   <= '{q: w_quo_e, r: w_rem_e};
        end else if (w_gen_fire && !w_gen_last) begin
            r_gen_k <= r_gen_k + 1'b1;
            r_acc_x <= n_acc_x;
            r_acc_z <= n_acc_z;
            r_acc_t <= n_acc_t;
            r_acc_y <= n_acc_y;
            r_acc_d <= n_acc_d;
        end
    end

    // ---------------------------------------------------------------
    // Output pipeline: capture, round, saturate
    // ---------------------------------------------------------------
    logic [MW-1:0]   r_a_k;
    logic            r_a_last, r_a_rej;
    t_acc            r_a_x, r_a_y, r_a_z, r_a_t;
    logic [VW-1:0]   r_a_m, r_a_m2;

    logic [MW-1:0]   r_b_k;
    logic            r_b_last, r_b_rej;
    logic [QW-1:0]   r_b_x, r_b_y, r_b_z, r_b_t;

    pas_pkg::t_smp   r_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            if (w_a_ready) begin
                r_a_v <= w_gen_fire;
            end
            if (w_b_ready) begin
                r_b_v <= r_a_v;
            end
            if (w_c_ready) begin
                r_c_v <= r_b_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // Capture the current sample numerators
        if (w_gen_fire && w_a_ready) begin
            r_a_k    <= r_gen_k;
            r_a_last <= w_gen_last;
            r_a_rej  <= r_gen_rej;
            r_a_x    <= r_acc_x;
            r_a_y    <= r_acc_y;
            r_a_z    <= r_acc_z;
            r_a_t    <= r_acc_t;
            r_a_m    <= w_gen_den;
            r_a_m2   <= r_gen_m2;
        end
        // Round once to Q16.16
        if (r_a_v && w_b_ready) begin
            r_b_k    <= r_a_k;
            r_b_last <= r_a_last;
            r_b_rej  <= r_a_rej;
            r_b_x    <= f_round(r_a_x, r_a_m);
            r_b_y    <= f_round(r_a_y, r_a_m2);
            r_b_z    <= f_round(r_a_z, r_a_m);
            r_b_t    <= f_round(r_a_t, r_a_m);
        end
        // Saturate, zero the fields of a rejected request
        if (r_b_v && w_c_ready) begin
            r_c.sample_index <= r_b_rej ? '0 : 6'(r_b_k);
            r_c.sample_time  <= r_b_rej ? '0 : f_sat(r_b_t);
            r_c.pos_x        <= r_b_rej ? '0 : f_sat(r_b_x);
            r_c.pos_y        <= r_b_rej ? '0 : f_sat(r_b_y);
            r_c.pos_z        <= r_b_rej ? '0 : f_sat(r_b_z);
            r_c.valid_res    <= !r_b_rej;
            r_c.last         <= r_b_last;
        end
    end

    assign o_smp.valid   = r_c_v;
    assign o_smp.payload = r_c;

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_fire |=> (r_st != pas_pkg::ST_IDLE))
        else $error("setup stayed idle after a request was accepted");

    a_index_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gen_busy && !r_gen_rej) |-> (r_gen_k <= r_gen_m))
        else $error("sample index ran past the end of the run");

    a_rem_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_v && !r_a_rej) |-> ((r_a_x.r < r_a_m) && (r_a_z.r < r_a_m) &&
                                 (r_a_t.r < r_a_m) && (r_a_y.r < r_a_m2)))
        else $error("running remainder not below its divisor");

    a_reject_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_smp.valid && !o_smp.payload.valid_res) |->
            (o_smp.payload.last && (o_smp.payload.sample_index == '0) &&
             (o_smp.payload.pos_y == '0) && (o_smp.payload.sample_time == '0)))
        else $error("rejected request result is not a single zeroed sample");
`endif

endmodule

/* tb/tb_parabolic_arc_sampler.sv */
`timescale 1ns / 100ps

module tb_parabolic_arc_sampler;

    localparam int          ARC_LIMIT   = pas_pkg::MAX_SAMPLES_DEF;
    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          TAIL_CYCLES = 64;
    localparam int          PHASE_ARCS  = 112;
    localparam logic [31:0] QMIN        = 32'h8000_0000;
    localparam logic [31:0] QMAX        = 32'h7FFF_FFFF;
    localparam logic [31:0] QONE        = 32'h0001_0000;

    // Answer to a rejected request: one sample, valid_res low, last high
    localparam pas_pkg::t_smp REJECTED = '{sample_index: '0, sample_time: '0, pos_x: '0,
                                           pos_y: '0, pos_z: '0, valid_res: 1'b0,
                                           last: 1'b1};

    // Directed request, with up to two samples typed in by hand (none: predicted)
    typedef struct packed {
        pas_pkg::t_req req;
        logic [1:0]    n_hand;
        pas_pkg::t_smp hand0;
        pas_pkg::t_smp hand1;
    } t_arc_row;

    logic      i_clk;
    logic      i_rst_n;
    pas_req_if req_if ();
    pas_smp_if smp_if ();

    pas_pkg::t_smp samples_due[$];
    t_arc_row      dir_rows[$];
    int            send_idle_pct = 0;
    int            stall_pct     = 0;
    int            mismatch_cnt  = 0;
    int            sample_cnt    = 0;
    int            cycle_cnt     = 0;

    parabolic_arc_sampler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_smp   (smp_if)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("parabolic_arc_sampler verification failed");
            $finish;
        end
    end

    // Stall the sample receiver at random
    initial smp_if.ready = 1'b0;
    always @(negedge i_clk) begin
        smp_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Divide by a positive denominator, round to nearest, ties away from zero
    function automatic longint round_div(input longint num, input longint den);
        if (num >= 0) begin
            return (num + den / 2) / den;
        end
        return -((-num + den / 2) / den);
    endfunction

    // Saturate to the Q16.16 range
    function automatic logic [31:0] clip_q16(input longint v);
        if (v > 64'sd2147483647) begin
            return QMAX;
        end
        if (v < -64'sd2147483648) begin
            return QMIN;
        end
        return v[31:0];
    endfunction

    // Straight-line point k of m along one axis
    function automatic longint span_point(input longint s, input longint e,
                                          input longint k, input longint m);
        return round_div(s * m + (e - s) * k, m);
    endfunction

    // Queue the samples one arc request must produce
    function automatic void plan_arc_samples(input pas_pkg::t_req r);
        longint        sx, sy, sz, ex, ey, ez, dur, lift, n, m, k, y;
        pas_pkg::t_smp s;
        sx   = longint'($signed(r.start_x));
        sy   = longint'($signed(r.start_y));
        sz   = longint'($signed(r.start_z));
        ex   = longint'($signed(r.end_x));
        ey   = longint'($signed(r.end_y));
        ez   = longint'($signed(r.end_z));
        dur  = longint'($signed(r.span_time));
        lift = longint'($signed(r.bump_height));
        n    = longint'(r.sample_count);
        if (dur <= 0 || n < 2) begin
            samples_due.push_back(REJECTED);
            return;
        end
        if (lift < 0) lift = 0;
        if (n > ARC_LIMIT) n = ARC_LIMIT;
        m = n - 1;
        for (k = 0; k < n; k++) begin
            // endpoints are exact; interior y carries the parabolic bump
            if (k == 0) begin
                y = sy;
            end else if (k == m) begin
                y = ey;
            end else begin
                y = round_div(sy * m * m + (ey - sy) * k * m + 4 * lift * k * (m - k), m * m);
            end
            s.sample_index = k[5:0];
            s.sample_time  = clip_q16(round_div(dur * k, m));
            s.pos_x        = clip_q16(k == 0 ? sx : (k == m ? ex : span_point(sx, ex, k, m)));
            s.pos_y        = clip_q16(y);
            s.pos_z        = clip_q16(k == 0 ? sz : (k == m ? ez : span_point(sz, ez, k, m)));
            s.valid_res    = 1'b1;
            s.last         = (k == m);
            samples_due.push_back(s);
        end
    endfunction

    function automatic pas_pkg::t_req mk_req(input logic [31:0] sx, input logic [31:0] sy,
                                             input logic [31:0] sz, input logic [31:0] ex,
                                             input logic [31:0] ey, input logic [31:0] ez,
                                             input logic [31:0] dur, input logic [31:0] lift,
                                             input logic [7:0] cnt);
        pas_pkg::t_req r;
        r.start_x      = sx;
        r.start_y      = sy;
        r.start_z      = sz;
        r.end_x        = ex;
        r.end_y        = ey;
        r.end_z        = ez;
        r.span_time    = dur;
        r.bump_height  = lift;
        r.sample_count = cnt;
        return r;
    endfunction

    function automatic pas_pkg::t_smp mk_smp(input logic [5:0] idx, input logic [31:0] stamp,
                                             input logic [31:0] x, input logic [31:0] y,
                                             input logic [31:0] z, input logic v,
                                             input logic l);
        pas_pkg::t_smp s;
        s.sample_index = idx;
        s.sample_time  = stamp;
        s.pos_x        = x;
        s.pos_y        = y;
        s.pos_z        = z;
        s.valid_res    = v;
        s.last         = l;
        return s;
    endfunction

    // Coordinate: extremes, small values around zero, or any 32-bit pattern
    function automatic logic [31:0] random_q16();
        case ($urandom_range(9))
            0:       return QMIN;
            1:       return QMAX;
            2, 3, 4: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed arcs with short runs; some rejects and clamped counts
    function automatic pas_pkg::t_req random_arc();
        pas_pkg::t_req r;
        int            pick;
        r = mk_req(random_q16(), random_q16(), random_q16(), random_q16(), random_q16(),
                   random_q16(), 32'h0, 32'h0, 8'd0);
        case ($urandom_range(3))
            0:       r.bump_height = $urandom;
            1:       r.bump_height = $urandom_range(0, 32'h0040_0000);
            default: r.bump_height = $urandom & QMAX;
        endcase
        if ($urandom_range(1) == 1) begin
            r.span_time = $urandom_range(1, QMAX);
        end else begin
            r.span_time = $urandom_range(1, 32'h0010_0000);
        end
        pick = $urandom_range(99);
        if (pick < 5) begin
            r.span_time = $urandom | QMIN;
        end else if (pick < 7) begin
            r.span_time = '0;
        end
        if (pick < 7) begin
            r.sample_count = 8'($urandom_range(255));
        end else if (pick < 11) begin
            r.sample_count = 8'($urandom_range(1));
        end else if (pick < 15) begin
            r.sample_count = 8'($urandom_range(ARC_LIMIT + 1, 255));
        end else if (pick < 60) begin
            r.sample_count = 8'($urandom_range(2, 16));
        end else begin
            r.sample_count = 8'($urandom_range(17, ARC_LIMIT));
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_cnt++;
        $display("%0t: sample %0d %s: got %h, want %h", $time, sample_cnt, what, got, want);
    endtask

    // Present one request; return at the falling edge after it is taken
    task automatic send_arc(input pas_pkg::t_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Hold off the sender until every sample due has come back
    task automatic drain_samples();
        while (samples_due.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Compare each sample taken with the oldest one due
    always @(posedge i_clk) begin : check_samples
        pas_pkg::t_smp got;
        pas_pkg::t_smp want;
        if (i_rst_n && smp_if.valid && smp_if.ready) begin
            got = smp_if.payload;
            if (samples_due.size() == 0) begin
                report_mismatch("arrived with nothing due, pos_x", got.pos_x, '0);
            end else begin
                want = samples_due.pop_front();
                if (got.sample_index !== want.sample_index)
                    report_mismatch("sample_index", 32'(got.sample_index),
                                    32'(want.sample_index));
                if (got.sample_time !== want.sample_time)
                    report_mismatch("sample_time", got.sample_time, want.sample_time);
                if (got.pos_x !== want.pos_x)
                    report_mismatch("pos_x", got.pos_x, want.pos_x);
                if (got.pos_y !== want.pos_y)
                    report_mismatch("pos_y", got.pos_y, want.pos_y);
                if (got.pos_z !== want.pos_z)
                    report_mismatch("pos_z", got.pos_z, want.pos_z);
                if (got.valid_res !== want.valid_res)
                    report_mismatch("valid_res", 32'(got.valid_res), 32'(want.valid_res));
                if (got.last !== want.last)
                    report_mismatch("last", 32'(got.last), 32'(want.last));
            end
            sample_cnt++;
        end
    end

    initial begin : stimulus
        pas_pkg::t_req arc;
        t_arc_row      row;
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;

        // Rejects: zero, negative and most negative duration; counts of zero and one
        dir_rows.push_back(t_arc_row'{mk_req(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
            32'h0004_0000, 32'h0005_0000, 32'h0006_0000, 32'h0, QONE, 8'd10), 2'd1,
            REJECTED, '0});
        dir_rows.push_back(t_arc_row'{mk_req(QONE, QONE, QONE, 32'h0, 32'h0, 32'h0,
            32'hFFFF_FFFF, QONE, 8'd10), 2'd1, REJECTED, '0});
        dir_rows.push_back(t_arc_row'{mk_req(QMIN, QMAX, QMIN, QMAX, QMIN, QMAX,
            QMIN, QMAX, 8'd64), 2'd1, REJECTED, '0});
        dir_rows.push_back(t_arc_row'{mk_req(QONE, QONE, QONE, QMAX, QMAX, QMAX,
            QONE, QONE, 8'd0), 2'd1, REJECTED, '0});
        dir_rows.push_back(t_arc_row'{mk_req(QONE, QONE, QONE, QMAX, QMAX, QMAX,
            QONE, QONE, 8'd1), 2'd1, REJECTED, '0});
        dir_rows.push_back(t_arc_row'{mk_req(QMAX, QMIN, QMAX, QMIN, QMAX, QMIN,
            32'h0, QMAX, 8'd0), 2'd1, REJECTED, '0});

        // Two samples: exactly the endpoints whatever the lift
        dir_rows.push_back(t_arc_row'{mk_req(QMIN, QMIN, QMIN, QMAX, QMAX, QMAX,
            QMAX, QMAX, 8'd2), 2'd2,
            mk_smp(6'd0, 32'h0, QMIN, QMIN, QMIN, 1'b1, 1'b0),
            mk_smp(6'd1, QMAX, QMAX, QMAX, QMAX, 1'b1, 1'b1)});
        dir_rows.push_back(t_arc_row'{mk_req(QMAX, QMAX, QMAX, QMIN, QMIN, QMIN,
            32'h1, QMIN, 8'd2), 2'd2,
            mk_smp(6'd0, 32'h0, QMAX, QMAX, QMAX, 1'b1, 1'b0),
            mk_smp(6'd1, 32'h1, QMIN, QMIN, QMIN, 1'b1, 1'b1)});
        dir_rows.push_back(t_arc_row'{mk_req(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
            32'h1, 32'h0, 8'd2), 2'd2,
            mk_smp(6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0),
            mk_smp(6'd1, 32'h1, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1)});

        // Count clamping, full-range spans and a lift that saturates y
        dir_rows.push_back(t_arc_row'{mk_req(QMIN, QMIN, QMIN, QMAX, QMAX, QMAX,
            QMAX, QMAX, 8'd255), 2'd0, '0, '0});
        dir_rows.push_back(t_arc_row'{mk_req(QMAX, QMIN, 32'h0, QMIN, QMAX, 32'h0,
            32'h0064_0000, 32'h0064_0000, 8'd64), 2'd0, '0, '0});
        dir_rows.push_back(t_arc_row'{mk_req(32'h0, 32'h0, 32'h0, 32'h0041_0000,
            32'hFFBF_0000, 32'h1234_5678, 32'h0040_0000, 32'h0001_8000, 8'd65), 2'd0,
            '0, '0});
        dir_rows.push_back(t_arc_row'{mk_req(32'h8765_4321, 32'h1357_9BDF, 32'hFEDC_BA98,
            32'h0123_4567, 32'hECA8_6420, 32'h7654_3210, 32'h00FF_FFFF, 32'h0100_0000,
            8'd128), 2'd0, '0, '0});
        dir_rows.push_back(t_arc_row'{mk_req(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
            32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'h2AAA_AAAA,
            8'd200), 2'd0, '0, '0});

        // Half-way ties, both signs; rounding goes away from zero
        dir_rows.push_back(t_arc_row'{mk_req(32'h0, 32'h0, 32'h0, 32'h1, 32'h1, 32'h1,
            32'h1, 32'h0, 8'd3), 2'd0, '0, '0});
        dir_rows.push_back(t_arc_row'{mk_req(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h3, 32'h0, 8'd3), 2'd0, '0, '0});

        // Large lift on a high path; negative lifts taken as flat
        dir_rows.push_back(t_arc_row'{mk_req(32'h0, 32'h7FFE_0000, 32'h0, QONE,
            32'h7FFE_0000, QONE, QONE, QMAX, 8'd3), 2'd0, '0, '0});
        dir_rows.push_back(t_arc_row'{mk_req(QONE, QONE, QONE, 32'h0005_0000,
            32'h0009_0000, 32'hFFFB_0000, 32'h0002_0000, 32'hFFFF_0000, 8'd5), 2'd0,
            '0, '0});
        dir_rows.push_back(t_arc_row'{mk_req(32'hFFF0_0000, 32'h0, 32'h0010_0000,
            32'h0010_0000, 32'h0, 32'hFFF0_0000, 32'h0000_8000, QMIN, 8'd9), 2'd0,
            '0, '0});

        // Ordinary arcs of assorted lengths
        dir_rows.push_back(t_arc_row'{mk_req(32'h0003_4000, 32'hFFFE_2000, 32'h0000_0100,
            32'hFFF8_8000, 32'h0007_C000, 32'h0011_0011, 32'h000A_0000, 32'h0004_0000,
            8'd17), 2'd0, '0, '0});
        dir_rows.push_back(t_arc_row'{mk_req(32'h7, 32'hFFFF_FFF9, 32'h3, 32'h1D,
            32'h11, 32'hFFFF_FFE3, 32'h21, 32'h5, 8'd33), 2'd0, '0, '0});
        dir_rows.push_back(t_arc_row'{mk_req(32'h4000_0000, 32'hC000_0000, 32'h1234_0000,
            32'hC000_0000, 32'h4000_0000, 32'hEDCC_0000, 32'h0ABC_DEF0, 32'h1000_0000,
            8'd63), 2'd0, '0, '0});

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests, back to back
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send_arc(row.req);
            if (row.n_hand == 2'd0) begin
                plan_arc_samples(row.req);
            end else begin
                samples_due.push_back(row.hand0);
                if (row.n_hand == 2'd2) samples_due.push_back(row.hand1);
            end
        end
        req_if.valid <= 1'b0;
        drain_samples();

        // Random requests under each idle and stall mix, draining between mixes
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 65;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 65;
                end
                default: begin
                    send_idle_pct = 28;
                    stall_pct     = 28;
                end
            endcase
            repeat (PHASE_ARCS) begin
                arc = random_arc();
                send_arc(arc);
                plan_arc_samples(arc);
            end
            req_if.valid <= 1'b0;
            drain_samples();
        end

        // Let any stray sample show up before the verdict
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("parabolic_arc_sampler verification clean");
        end else begin
            $display("parabolic_arc_sampler verification failed");
        end
        $finish;
    end

endmodule

/* parabolic_arc_sampler.f */
sv/pas_pkg.sv
sv/pas_if.sv
sv/pas_div_lane.sv
sv/parabolic_arc_sampler.sv
tb/tb_parabolic_arc_sampler.sv
